### hw/rtl/ffbc_pkg.sv
// Package with types, constants and helpers of the flat-field background corrector.
package ffbc_pkg;

    localparam int PIXEL_BITS = 16;
    localparam int MAX_PIXELS = 65536;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_BITS  = $clog2(MAX_PIXELS);
    localparam int NPIX_BITS  = ADDR_BITS + 1;
    localparam int SUM_BITS   = 32;
    localparam int TOTAL_BITS = SUM_BITS + ADDR_BITS;
    localparam int ENTRY_BITS = SUM_BITS + COUNT_BITS;

    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX = {SUM_BITS{1'b1}};

    localparam logic [15:0] LOW_THRESHOLD_RESET  = 16'd20000;
    localparam logic [15:0] HIGH_THRESHOLD_RESET = 16'd65535;
    localparam logic [16:0] PIXEL_COUNT_RESET    = 17'd65536;

    // Commands.
    localparam logic [2:0] CMD_CLEAR      = 3'd0;
    localparam logic [2:0] CMD_ACCUMULATE = 3'd1;
    localparam logic [2:0] CMD_FINISH     = 3'd2;
    localparam logic [2:0] CMD_READ       = 3'd3;
    localparam logic [2:0] CMD_CORRECT    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_MEAN       = 2'd0;
    localparam logic [1:0] KIND_BACKGROUND = 2'd1;
    localparam logic [1:0] KIND_CORRECTED  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_PIXEL_COUNT    = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] pixel_index;
        logic [15:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] result_index;
        logic [15:0] result_value;
    } out_item_t;

    function automatic logic [15:0] clamp_pix(input logic [TOTAL_BITS-1:0] v);
        logic [15:0] r;
        if (v > TOTAL_BITS'(PIX_MAX)) begin
            r = 16'(PIX_MAX);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/ffbc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ffbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/ffbc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ffbc_div
    import ffbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TOTAL_BITS-1:0] dividend,
    input  logic [SUM_BITS-1:0]   divisor,
    output logic                  done,
    output logic [TOTAL_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(TOTAL_BITS);

    logic                  busy_reg;
    logic [STEP_BITS-1:0]  step_reg;
    logic [TOTAL_BITS-1:0] quo_reg;
    logic [SUM_BITS-1:0]   rem_reg;
    logic [SUM_BITS-1:0]   dvs_reg;
    logic [SUM_BITS:0]     shifted;
    logic                  fits;

    assign shifted  = {rem_reg, quo_reg[TOTAL_BITS-1]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(TOTAL_BITS - 1);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= fits ? SUM_BITS'(shifted - {1'b0, dvs_reg})
                                : shifted[SUM_BITS-1:0];
                quo_reg <= {quo_reg[TOTAL_BITS-2:0], fits};
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end else begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/flat_field_background_correct.sv
// Top level of the flat-field background builder and pixel corrector.
//
//  channel | direction | handshake             | payload
//  s_      | in        | s_valid / s_ready     | s_data (in_item_t)
//  m_      | out       | m_valid / m_ready     | m_data (out_item_t)
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Work per item with a free result slot: accumulate updates the pixel's entry (skipped
// when the pixel is not in use or the background is finished), read fetches the entry,
// correct fetches it and runs the shared divider unless the background is zero, finish
// divides each pixel in use with a nonzero count (unless already finished) and then the
// total for the mean, and clear sweeps through the whole pixel store.
// After reset the same sweep clears the store, so s_ready stays low until it is done.
// A result waits in the output register while the next transfer is taken; a new
// result is only written there once the waiting one has been taken.
module flat_field_background_correct
    import ffbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLEAR     = 4'd1;
    localparam logic [3:0] ST_ACC_WR    = 4'd2;
    localparam logic [3:0] ST_FIN_RD    = 4'd3;
    localparam logic [3:0] ST_FIN_CHK   = 4'd4;
    localparam logic [3:0] ST_FIN_DIV   = 4'd5;
    localparam logic [3:0] ST_MEAN_GO   = 4'd6;
    localparam logic [3:0] ST_MEAN_DIV  = 4'd7;
    localparam logic [3:0] ST_READ_DATA = 4'd8;
    localparam logic [3:0] ST_COR_DATA  = 4'd9;
    localparam logic [3:0] ST_COR_DIV   = 4'd10;
    localparam logic [3:0] ST_OUT       = 4'd11;

    logic [3:0]           state_reg;
    logic [15:0]          low_reg;
    logic [15:0]          high_reg;
    logic [NPIX_BITS-1:0] npix_reg;
    logic [15:0]          mean_reg;
    logic                 finished_reg;
    logic [ADDR_BITS-1:0] walk_reg;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] cnt_hold_reg;
    logic [ADDR_BITS-1:0] idx_reg;
    logic [15:0]          val_reg;
    logic                 used_reg;
    logic                 in_range_reg;
    out_item_t            res_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic [NPIX_BITS-1:0] n_use;
    logic                 s_used;
    logic                 s_fire;
    logic                 last_pixel;

    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [ENTRY_BITS-1:0]  ram_wdata;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [ENTRY_BITS-1:0]  ram_rdata;
    logic [SUM_BITS-1:0]    rd_sum;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [SUM_BITS:0]      acc_sum;
    logic [SUM_BITS-1:0]    new_sum;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [SUM_BITS-1:0]    product;
    logic [SUM_BITS-1:0]    bg;

    logic                  div_start;
    logic [TOTAL_BITS-1:0] div_dividend;
    logic [SUM_BITS-1:0]   div_divisor;
    logic                  div_done;
    logic [TOTAL_BITS-1:0] div_quotient;

    // Pixels in use: the configured count, capped at the store depth.
    assign n_use = (npix_reg > NPIX_BITS'(MAX_PIXELS)) ? NPIX_BITS'(MAX_PIXELS) : npix_reg;
    assign s_used = {1'b0, s_data.pixel_index} < 17'(n_use);
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign last_pixel = (NPIX_BITS'(walk_reg) + 1'b1) == n_use;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Each store entry holds the count above the sum.
    assign rd_sum  = ram_rdata[SUM_BITS-1:0];
    assign rd_cnt  = ram_rdata[ENTRY_BITS-1:SUM_BITS];
    assign acc_sum = {1'b0, rd_sum} + (SUM_BITS + 1)'(val_reg);
    assign new_sum = acc_sum[SUM_BITS] ? SUM_MAX : acc_sum[SUM_BITS-1:0];
    assign new_cnt = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
    assign product = mean_reg * val_reg;
    assign bg      = used_reg ? rd_sum : '0;

    // The read address follows the incoming transfer while idle, so the entry is
    // ready in the cycle after the transfer; during finish it follows the walk.
    assign ram_raddr = (state_reg == ST_IDLE) ? s_data.pixel_index[ADDR_BITS-1:0] : walk_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = walk_reg;
        ram_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
            end
            ST_ACC_WR: begin
                ram_we    = in_range_reg;
                ram_waddr = idx_reg;
                ram_wdata = {new_cnt, new_sum};
            end
            ST_FIN_DIV: begin
                ram_we    = div_done;
                ram_wdata = {cnt_hold_reg, div_quotient[SUM_BITS-1:0]};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = TOTAL_BITS'(product);
        div_divisor  = bg;
        case (state_reg)
            ST_FIN_CHK: begin
                div_start    = !finished_reg && (rd_cnt != '0);
                div_dividend = TOTAL_BITS'(rd_sum);
                div_divisor  = SUM_BITS'(rd_cnt);
            end
            ST_MEAN_GO: begin
                div_start    = 1'b1;
                div_dividend = total_reg;
                div_divisor  = SUM_BITS'(n_use);
            end
            ST_COR_DATA: begin
                div_start = (bg != '0);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    ffbc_ram #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(MAX_PIXELS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffbc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_THRESHOLD_RESET;
            high_reg <= HIGH_THRESHOLD_RESET;
            npix_reg <= PIXEL_COUNT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_LOW_THRESHOLD:  low_reg  <= cfg_data[15:0];
                REG_HIGH_THRESHOLD: high_reg <= cfg_data[15:0];
                REG_PIXEL_COUNT:    npix_reg <= cfg_data[NPIX_BITS-1:0];
                default:            low_reg  <= low_reg;
            endcase
        end
    end

    // Output register: the pending result moves here once the slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            walk_reg     <= '0;
            mean_reg     <= '0;
            finished_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        idx_reg      <= s_data.pixel_index[ADDR_BITS-1:0];
                        val_reg      <= s_data.pixel_value;
                        used_reg     <= s_used;
                        in_range_reg <= (s_data.pixel_value >= low_reg) &&
                                        (s_data.pixel_value <= high_reg);
                        walk_reg     <= '0;
                        total_reg    <= '0;
                        // The mean carries index zero; every other result its pixel.
                        res_reg.result_index <= (s_data.command == CMD_FINISH) ?
                                                16'd0 : s_data.pixel_index;
                        case (s_data.command)
                            CMD_CLEAR: begin
                                mean_reg     <= '0;
                                finished_reg <= 1'b0;
                                state_reg    <= ST_CLEAR;
                            end
                            CMD_ACCUMULATE: begin
                                state_reg <= (s_used && !finished_reg) ? ST_ACC_WR : ST_IDLE;
                            end
                            CMD_FINISH: begin
                                res_reg.result_kind  <= KIND_MEAN;
                                res_reg.result_value <= '0;
                                if (n_use == '0) begin
                                    finished_reg <= 1'b1;
                                    mean_reg     <= '0;
                                    state_reg    <= ST_OUT;
                                end else begin
                                    state_reg <= ST_FIN_RD;
                                end
                            end
                            CMD_READ: begin
                                state_reg <= ST_READ_DATA;
                            end
                            CMD_CORRECT: begin
                                state_reg <= ST_COR_DATA;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CLEAR: begin
                    walk_reg <= walk_reg + 1'b1;
                    if (walk_reg == {ADDR_BITS{1'b1}}) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ACC_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_FIN_RD: begin
                    state_reg <= ST_FIN_CHK;
                end
                ST_FIN_CHK: begin
                    cnt_hold_reg <= rd_cnt;
                    if (div_start) begin
                        state_reg <= ST_FIN_DIV;
                    end else begin
                        total_reg <= total_reg + TOTAL_BITS'(rd_sum);
                        walk_reg  <= walk_reg + 1'b1;
                        state_reg <= last_pixel ? ST_MEAN_GO : ST_FIN_RD;
                    end
                end
                ST_FIN_DIV: begin
                    if (div_done) begin
                        total_reg <= total_reg + TOTAL_BITS'(div_quotient[SUM_BITS-1:0]);
                        walk_reg  <= walk_reg + 1'b1;
                        state_reg <= last_pixel ? ST_MEAN_GO : ST_FIN_RD;
                    end
                end
                ST_MEAN_GO: begin
                    state_reg <= ST_MEAN_DIV;
                end
                ST_MEAN_DIV: begin
                    if (div_done) begin
                        mean_reg             <= clamp_pix(div_quotient);
                        finished_reg         <= 1'b1;
                        res_reg.result_value <= clamp_pix(div_quotient);
                        state_reg            <= ST_OUT;
                    end
                end
                ST_READ_DATA: begin
                    res_reg.result_kind  <= KIND_BACKGROUND;
                    res_reg.result_value <= clamp_pix(TOTAL_BITS'(bg));
                    state_reg            <= ST_OUT;
                end
                ST_COR_DATA: begin
                    res_reg.result_kind  <= KIND_CORRECTED;
                    res_reg.result_value <= clamp_pix(TOTAL_BITS'(product));
                    state_reg            <= div_start ? ST_COR_DIV : ST_OUT;
                end
                ST_COR_DIV: begin
                    if (div_done) begin
                        res_reg.result_value <= clamp_pix(div_quotient);
                        state_reg            <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/ffbc_checker.sv
// Port-level checker of the flat-field corrector and its bind statement.
module ffbc_checker
    import ffbc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset starts the clearing sweep, so no transfer is taken right after it.
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result_kind == KIND_MEAN ||
                     m_data.result_kind == KIND_BACKGROUND ||
                     m_data.result_kind == KIND_CORRECTED))
        else $error("unknown result kind");

    a_mean_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_kind == KIND_MEAN |-> m_data.result_index == '0)
        else $error("mean result with nonzero index");

endmodule

bind flat_field_background_correct ffbc_checker u_ffbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

### tb/sv/tb_flat_field_background_correct.sv
// Testbench for the flat-field background builder: directed tests, then random item streams.
`timescale 1ns / 1ps

module tb_flat_field_background_correct;
    import ffbc_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    flat_field_background_correct dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the background store and registers, updated on each accepted transfer.
    logic [31:0] bg_sum [0:MAX_PIXELS-1];
    logic [15:0] bg_count [0:MAX_PIXELS-1];
    logic [15:0] mean_shadow;
    logic        finished_shadow;
    logic [15:0] low_shadow;
    logic [15:0] high_shadow;
    logic [16:0] npix_shadow;

    out_item_t pending_results[$];
    int        mismatches;
    int        cycles;
    bit        stall_enable;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Random gap length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] clamp16(input logic [63:0] v);
        return (v > 64'(PIX_MAX)) ? PIX_MAX : v[15:0];
    endfunction

    function automatic int unsigned pixels_in_use();
        return (npix_shadow > MAX_PIXELS) ? MAX_PIXELS : npix_shadow;
    endfunction

    // Appends one expected result to the end of the queue.
    function automatic void add_expected(input out_item_t r);
        pending_results = {pending_results, r};
    endfunction

    task automatic wipe_background();
        for (int j = 0; j < MAX_PIXELS; j++) begin
            bg_sum[j]   = '0;
            bg_count[j] = '0;
        end
        mean_shadow     = '0;
        finished_shadow = 1'b0;
    endtask

    // Updates the shadow store for one accepted item and queues its result, if any.
    task automatic apply_command(input in_item_t it);
        int unsigned n;
        logic        in_use;
        logic [63:0] total;
        logic [63:0] prod;
        logic [63:0] bgv;
        logic [32:0] s;
        out_item_t   r;
        n      = pixels_in_use();
        in_use = it.pixel_index < n;
        case (it.command)
            CMD_CLEAR: begin
                wipe_background();
            end
            CMD_ACCUMULATE: begin
                if (in_use && !finished_shadow &&
                    it.pixel_value >= low_shadow && it.pixel_value <= high_shadow) begin
                    s = bg_sum[it.pixel_index] + it.pixel_value;
                    bg_sum[it.pixel_index] = s[32] ? SUM_MAX : s[31:0];
                    if (bg_count[it.pixel_index] != CNT_MAX) begin
                        bg_count[it.pixel_index] = bg_count[it.pixel_index] + 1'b1;
                    end
                end
            end
            CMD_FINISH: begin
                total = '0;
                for (int unsigned j = 0; j < n; j++) begin
                    if (!finished_shadow && bg_count[j] != 0) begin
                        bg_sum[j] = bg_sum[j] / bg_count[j];
                    end
                    total += bg_sum[j];
                end
                finished_shadow = 1'b1;
                mean_shadow     = (n != 0) ? clamp16(total / n) : 16'd0;
                r.result_kind   = KIND_MEAN;
                r.result_index  = '0;
                r.result_value  = mean_shadow;
                add_expected(r);
            end
            CMD_READ: begin
                r.result_kind  = KIND_BACKGROUND;
                r.result_index = it.pixel_index;
                r.result_value = in_use ? clamp16(64'(bg_sum[it.pixel_index])) : 16'd0;
                add_expected(r);
            end
            CMD_CORRECT: begin
                bgv  = in_use ? 64'(bg_sum[it.pixel_index]) : 64'd0;
                prod = 64'(mean_shadow) * 64'(it.pixel_value);
                if (bgv != 0) begin
                    prod = prod / bgv;
                end
                r.result_kind  = KIND_CORRECTED;
                r.result_index = it.pixel_index;
                r.result_value = clamp16(prod);
                add_expected(r);
            end
            default: begin
                // Unknown commands leave everything alone.
            end
        endcase
    endtask

    // Drives one item and holds it until the transfer, then optionally idles.
    task automatic send_item(input logic [2:0] cmd, input logic [15:0] idx,
                             input logic [15:0] val, input bit use_gap);
        in_item_t it;
        int       g;
        it.command     = cmd;
        it.pixel_index = idx;
        it.pixel_value = val;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_command(it);
        g = use_gap ? pick_gap() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    // Lowers valid, then waits until every queued result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // A trailing read marks the point where earlier silent work (clear included) is done.
    task automatic settle();
        send_item(CMD_READ, 16'd0, 16'd0, 1'b0);
        drain();
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LOW_THRESHOLD:  low_shadow  = val[15:0];
            REG_HIGH_THRESHOLD: high_shadow = val[15:0];
            REG_PIXEL_COUNT:    npix_shadow = val[16:0];
            default: ;
        endcase
    endtask

    // Store as it is after reset: reads, corrections and unknown commands on empty pixels.
    task automatic test_empty_store();
        send_item(CMD_READ, 16'd0, 16'd0, 1'b1);
        send_item(CMD_READ, 16'hFFFF, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd7, 16'hFFFF, 1'b1);
        send_item(3'd5, 16'd1, 16'd1, 1'b1);
        send_item(3'd7, 16'hFFFF, 16'hFFFF, 1'b1);
        settle();
    endtask

    // Thresholds, including the crossed case, pixels out of use, and raw sums read and corrected before finishing.
    task automatic test_thresholds();
        write_reg(REG_PIXEL_COUNT, 32'd16);
        write_reg(REG_LOW_THRESHOLD, 32'd40000);
        write_reg(REG_HIGH_THRESHOLD, 32'd100);
        send_item(CMD_ACCUMULATE, 16'd3, 16'd50, 1'b1);
        send_item(CMD_ACCUMULATE, 16'd3, 16'd40000, 1'b1);
        send_item(CMD_READ, 16'd3, 16'd0, 1'b1);
        settle();
        write_reg(REG_LOW_THRESHOLD, 32'd0);
        write_reg(REG_HIGH_THRESHOLD, 32'd65535);
        send_item(CMD_ACCUMULATE, 16'd0, 16'd0, 1'b1);
        send_item(CMD_ACCUMULATE, 16'd15, 16'hFFFF, 1'b1);
        send_item(CMD_ACCUMULATE, 16'd15, 16'hFFFF, 1'b1);
        send_item(CMD_ACCUMULATE, 16'd16, 16'd500, 1'b1);
        send_item(CMD_ACCUMULATE, 16'hFFFF, 16'd500, 1'b1);
        send_item(CMD_READ, 16'd15, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd15, 16'd1234, 1'b1);
        settle();
    endtask

    // Finish, corrections, accumulation after finish, repeated and empty finishes, an oversized count and a clear.
    task automatic test_finish();
        send_item(CMD_FINISH, 16'd0, 16'd0, 1'b1);
        send_item(CMD_READ, 16'd15, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd15, 16'hFFFF, 1'b1);
        send_item(CMD_CORRECT, 16'd4, 16'hFFFF, 1'b1);
        send_item(CMD_CORRECT, 16'd15, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd200, 16'd9, 1'b1);
        send_item(CMD_ACCUMULATE, 16'd1, 16'd3000, 1'b1);
        send_item(CMD_READ, 16'd1, 16'd0, 1'b1);
        settle();
        write_reg(REG_PIXEL_COUNT, 32'd4);
        send_item(CMD_FINISH, 16'd0, 16'd0, 1'b1);
        settle();
        write_reg(REG_PIXEL_COUNT, 32'd0);
        send_item(CMD_FINISH, 16'd0, 16'd0, 1'b1);
        send_item(CMD_READ, 16'd0, 16'd0, 1'b1);
        settle();
        // A count above the store size acts as the full store.
        write_reg(REG_PIXEL_COUNT, 32'h1FFFF);
        send_item(CMD_READ, 16'hFFFF, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd15, 16'd777, 1'b1);
        settle();
        write_reg(REG_PIXEL_COUNT, 32'd65536);
        send_item(CMD_CLEAR, 16'd0, 16'd0, 1'b1);
        settle();
    endtask

    // One pixel fed the maximum value back to back, so its raw sum is read back clamped.
    task automatic test_saturation();
        write_reg(REG_PIXEL_COUNT, 32'd1);
        write_reg(REG_LOW_THRESHOLD, 32'd65535);
        write_reg(REG_HIGH_THRESHOLD, 32'd65535);
        for (int k = 0; k < 40; k++) begin
            send_item(CMD_ACCUMULATE, 16'd0, 16'hFFFF, 1'b0);
        end
        send_item(CMD_READ, 16'd0, 16'd0, 1'b1);
        send_item(CMD_FINISH, 16'd0, 16'd0, 1'b1);
        send_item(CMD_READ, 16'd0, 16'd0, 1'b1);
        send_item(CMD_CORRECT, 16'd0, 16'hFFFF, 1'b1);
        send_item(CMD_CLEAR, 16'd0, 16'd0, 1'b1);
        settle();
    endtask

    // Random epochs: build a background, finish, then correct and read against it.
    task automatic test_random();
        int unsigned n;
        int          r;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] idx;
        for (int epoch = 0; epoch < 3; epoch++) begin
            n  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(8, 64);
            lo = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30000));
            hi = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(35000, 65535));
            write_reg(REG_PIXEL_COUNT, 32'(n));
            write_reg(REG_LOW_THRESHOLD, 32'(lo));
            write_reg(REG_HIGH_THRESHOLD, 32'(hi));
            for (int k = 0; k < 300; k++) begin
                r   = $urandom_range(0, 99);
                idx = (r < 92 && n != 0) ? 16'($urandom_range(0, n - 1)) : 16'($urandom);
                if (r < 85) begin
                    send_item(CMD_ACCUMULATE, idx, 16'($urandom), 1'b1);
                end else if (r < 92) begin
                    send_item(CMD_READ, idx, 16'($urandom), 1'b1);
                end else if (r < 96) begin
                    send_item(CMD_CORRECT, idx, 16'($urandom), 1'b1);
                end else begin
                    send_item(3'($urandom_range(5, 7)), idx, 16'($urandom), 1'b1);
                end
            end
            send_item(CMD_FINISH, 16'($urandom), 16'($urandom), 1'b1);
            for (int k = 0; k < 320; k++) begin
                r   = $urandom_range(0, 99);
                idx = (r < 90 && n != 0) ? 16'($urandom_range(0, n - 1)) : 16'($urandom);
                if (r < 60) begin
                    send_item(CMD_CORRECT, idx, 16'($urandom), 1'b1);
                end else if (r < 88) begin
                    send_item(CMD_READ, idx, 16'($urandom), 1'b1);
                end else if (r < 94) begin
                    send_item(CMD_ACCUMULATE, idx, 16'($urandom), 1'b1);
                end else if (r < 97) begin
                    send_item(CMD_FINISH, idx, 16'($urandom), 1'b1);
                end else begin
                    send_item(3'($urandom_range(5, 7)), idx, 16'($urandom), 1'b1);
                end
            end
            send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'b1);
            settle();
        end
    endtask

    // Result side: random back-pressure, with stretches of none.
    always @(posedge aclk) begin
        if (!aresetn || !stall_enable) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 99) < 30) begin
            m_ready <= (pick_gap() == 0);
        end
    end

    // Every result transfer is matched against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result kind=%0d index=%0d value=%0d",
                             m_data.result_kind, m_data.result_index, m_data.result_value);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected kind=%0d index=%0d value=%0d, got %0d %0d %0d",
                                 want.result_kind, want.result_index, want.result_value,
                                 m_data.result_kind, m_data.result_index,
                                 m_data.result_value);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL flat_field_background_correct");
            $finish;
        end
    end

    initial begin
        mismatches   = 0;
        cycles       = 0;
        stall_enable = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b1;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        low_shadow   = LOW_THRESHOLD_RESET;
        high_shadow  = HIGH_THRESHOLD_RESET;
        npix_shadow  = PIXEL_COUNT_RESET;
        wipe_background();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        stall_enable = 1'b1;

        test_empty_store();
        test_thresholds();
        test_finish();
        test_saturation();
        test_random();

        drain();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS flat_field_background_correct");
        end else begin
            $display("FAIL flat_field_background_correct");
        end
        $finish;
    end

endmodule
